[src/vertex_dedup_table_unit_defines.svh]
// Assertion macros for the vertex dedup table.
`ifndef VERTEX_DEDUP_TABLE_UNIT_DEFINES_SVH
`define VERTEX_DEDUP_TABLE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define VDT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vdt check failed");

// Next-cycle implication.
`define VDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vdt check failed");

`endif

[src/vdt_pkg.sv]
package vdt_pkg;
    localparam int unsigned DefTableDepth = 1024;
    localparam int unsigned VertexW = 8 * 32 + 26;
    localparam int unsigned InDataW = 288;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLEARED  = 2'd3
    } vdt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_CMP,
        S_WRITE,
        S_OUT
    } vdt_state_t;

    // controller -> datapath
    typedef struct packed {
        logic        load;      // capture input item
        logic        clr_count;
        logic        scan_rst;  // scan pointer to zero
        logic        scan_inc;
        logic        wr_en;     // store vertex at entry_count
        logic        res_load;
        vdt_status_t res_status;
        logic        res_from_scan; // index = scan pointer, else count or zero
        logic        res_use_count;
        logic        out_load;  // staged result into the output register
    } vdt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic scan_end;  // scan pointer reached entry_count
        logic match;     // registered entry equals captured vertex
        logic full;
    } vdt_stat_t;
endpackage

[src/vertex_dedup_table_unit.sv]
// Vertex dedup table: a lookup scans stored entries one at a time, each through the READ,
// WAIT and CMP states (one RAM read port, registered read, compare). One item is in work
// at a time; the next is accepted in the cycle after its result moves to the output
// register, where a stalled result holds it only at the final step.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
`include "vertex_dedup_table_unit_defines.svh"

module vertex_dedup_table_unit import vdt_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
    // texture_number, shade_color, plane_flag (282 bits, zero padded)
    input  logic [InDataW-1:0] s_tdata,
    // command
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // vertex_index, status
    output logic [15:0]        m_tdata
);
    vdt_cmd_t    cmd;
    vdt_stat_t   stat;
    logic [9:0]  res_index;
    vdt_status_t res_status;

    vdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // the packed vertex word compares all eleven attributes bit for bit
    vdt_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_command (s_tuser),
        .in_vertex  (s_tdata[VertexW-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .res_index  (res_index),
        .res_status (res_status)
    );

    assign m_tdata = {4'd0, res_status, res_index};

    `VDT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `VDT_ASSERT_IMPL(a_single_op, aclk, aresetn, cmd.wr_en, !cmd.clr_count)
    `VDT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

[src/vdt_ram.sv]
module vdt_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[src/vdt_ctrl.sv]
module vdt_ctrl import vdt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  vdt_stat_t stat,
    output vdt_cmd_t  cmd
);
    vdt_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign s_tready = (state_reg == S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_READ;
            S_READ: begin
                if (stat.is_clear || stat.scan_end) state_next = S_WRITE;
                else state_next = S_WAIT;
            end
            S_WAIT:  state_next = S_CMP;
            S_CMP: begin
                if (stat.match) state_next = S_OUT;
                else state_next = S_READ;
            end
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        cmd.res_status = ST_HIT;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load     = s_tvalid;
                cmd.scan_rst = s_tvalid;
            end
            S_READ:  ;
            S_WAIT:  ;
            S_CMP: begin
                cmd.res_from_scan = 1'b1;
                cmd.res_load      = stat.match;
                cmd.scan_inc      = !stat.match;
            end
            S_WRITE: begin
                cmd.res_load = 1'b1;
                if (stat.is_clear) begin
                    cmd.clr_count  = 1'b1;
                    cmd.res_status = ST_CLEARED;
                end else if (stat.full) begin
                    cmd.res_status = ST_FULL;
                end else begin
                    cmd.wr_en         = 1'b1;
                    cmd.res_use_count = 1'b1;
                    cmd.res_status    = ST_INSERTED;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    cmd.out_load   = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

[src/vdt_datapath.sv]
module vdt_datapath import vdt_pkg::*; #(
    parameter int unsigned TableDepth = DefTableDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_command,
    input  logic [VertexW-1:0] in_vertex,
    input  vdt_cmd_t           cmd,
    output vdt_stat_t          stat,
    output logic [9:0]         res_index,
    output vdt_status_t        res_status
);
    localparam int unsigned AW = $clog2(TableDepth);
    localparam int unsigned CW = $clog2(TableDepth + 1);

    logic [CW-1:0]      count_reg, scan_reg;
    logic               clear_reg;
    logic [VertexW-1:0] vert_reg, rd_data;
    logic [9:0]         idx_reg;
    vdt_status_t        stat_reg;
    logic [9:0]         out_idx_reg;
    vdt_status_t        out_stat_reg;
    logic [CW-1:0]      idx_src;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clr_count) begin
            count_reg <= '0;
        end else if (cmd.wr_en) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clear_reg <= in_command;
            vert_reg  <= in_vertex;
        end
        if (cmd.scan_rst) scan_reg <= '0;
        else if (cmd.scan_inc) scan_reg <= scan_reg + CW'(1);
        if (cmd.res_load) begin
            idx_reg  <= 10'(idx_src);
            stat_reg <= cmd.res_status;
        end
        if (cmd.out_load) begin
            out_idx_reg  <= idx_reg;
            out_stat_reg <= stat_reg;
        end
    end

    always_comb begin
        if (cmd.res_from_scan) idx_src = scan_reg;
        else if (cmd.res_use_count) idx_src = count_reg;
        else idx_src = '0;
    end

    // one whole vertex per entry; read address held through WAIT
    vdt_ram #(.Width(VertexW), .Depth(TableDepth)) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (vert_reg),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign stat.is_clear = clear_reg;
    assign stat.scan_end = (scan_reg == count_reg);
    assign stat.match    = (rd_data == vert_reg);
    assign stat.full     = (count_reg == CW'(TableDepth));
    assign res_index     = out_idx_reg;
    assign res_status    = out_stat_reg;
endmodule

[bench/vertex_dedup_table_unit_tb.sv]
module vertex_dedup_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdt_pkg::*;

    localparam int unsigned Depth = DefTableDepth;
    localparam longint unsigned CycleLimit = 64'd20_000_000;

    // One vertex as it travels in tdata, pos_x lowest.
    typedef struct packed {
        logic        plane_flag;
        logic [7:0]  shade_color;
        logic [16:0] texture_number;
        logic [31:0] tex_v;
        logic [31:0] tex_u;
        logic [31:0] normal_z;
        logic [31:0] normal_y;
        logic [31:0] normal_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } vertex_t;

    // status above vertex_index, as packed in m_tdata
    typedef struct packed {
        vdt_status_t status;
        logic [9:0]  vertex_index;
    } answer_t;

    // Scoreboard: own copy of the weld table and a queue of expected answers.
    class weld_scoreboard;
        vertex_t     table_q[$];
        answer_t     pending_q[$];
        int          mismatches;

        function void note_item(logic clear_cmd, vertex_t v);
            answer_t a;
            int      hit;
            hit = -1;
            if (clear_cmd) begin
                table_q.delete();
                a.vertex_index = '0;
                a.status = ST_CLEARED;
            end else begin
                foreach (table_q[i]) begin
                    if (hit < 0 && table_q[i] == v) hit = i;
                end
                if (hit >= 0) begin
                    a.vertex_index = hit[9:0];
                    a.status = ST_HIT;
                end else if (table_q.size() >= Depth) begin
                    a.vertex_index = '0;
                    a.status = ST_FULL;
                end else begin
                    a.vertex_index = 10'(table_q.size());
                    a.status = ST_INSERTED;
                    table_q = {table_q, v};
                end
            end
            pending_q = {pending_q, a};
        endfunction

        task check_answer(logic [15:0] data);
            answer_t got;
            answer_t exp_a;
            got = data[11:0];
            if (pending_q.size() == 0) begin
                report_mismatch("answer with nothing expected", data, '0);
                return;
            end
            exp_a = pending_q.pop_front();
            if (got.status !== exp_a.status)
                report_mismatch("status", 16'(got.status), 16'(exp_a.status));
            if (got.vertex_index !== exp_a.vertex_index)
                report_mismatch("vertex_index", 16'(got.vertex_index),
                                16'(exp_a.vertex_index));
        endtask

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [InDataW-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;

    weld_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;          // long receiver stall, driven by its own process
    longint unsigned cycles;
    vertex_t pool[$];       // vertices already sent, reused to provoke hits

    vertex_dedup_table_unit #(.TABLE_DEPTH(Depth)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls plus the long hold-off; check on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_answer(m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic vertex_t random_vertex();
        vertex_t v;
        v = $bits(vertex_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom});
        // texture id set to -1 (all ones) now and then
        if ($urandom_range(3) == 0) v.texture_number = '1;
        return v;
    endfunction

    // Offer one item and wait for it to be taken; tvalid stays up for a following
    // item unless the sender idles.
    task automatic send_item(logic clear_cmd, vertex_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= clear_cmd;
        s_tdata  <= InDataW'(v);
        do @(posedge aclk); while (!s_tready);
        sb.note_item(clear_cmd, v);
        if (!clear_cmd) pool = {pool, v};
        if (clear_cmd) pool.delete();
    endtask

    task automatic send_lookup();
        vertex_t v;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pool.size() != 0 && pick < 40) begin
            v = pool[$urandom_range(pool.size() - 1)];
        end else if (pool.size() != 0 && pick < 55) begin
            // near miss: one bit flipped in a stored vertex
            v = pool[$urandom_range(pool.size() - 1)];
            v[$urandom_range($bits(vertex_t) - 1)] ^= 1'b1;
        end else begin
            v = random_vertex();
        end
        send_item(1'b0, v);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        vertex_t v;
        sb = new();
        cycles = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, hit, one-field differences, clear.
        send_item(1'b0, '0);
        send_item(1'b0, '1);
        send_item(1'b0, '0);
        v = '0;
        v.pos_x = 32'h8000_0000; v.pos_y = 32'h7fff_ffff; v.texture_number = '1;
        send_item(1'b0, v);
        v.plane_flag = 1'b1;
        send_item(1'b0, v);
        v.shade_color = 8'hff;
        send_item(1'b0, v);
        v.texture_number = 17'h0ffff;
        send_item(1'b0, v);
        v.texture_number = 17'h10000;   // out-of-range id pattern, stored as is
        send_item(1'b0, v);
        send_item(1'b0, v);
        send_item(1'b0, '1);
        send_item(1'b1, '1);            // clear; vertex fields ignored
        send_item(1'b0, '1);
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        wait_drained();

        // Fill the table to capacity, then miss (full) and hit.
        for (int i = 0; i < Depth; i++) begin
            v = '0;
            v.pos_x = i;
            send_item(1'b0, v);
        end
        send_item(1'b0, random_vertex());
        v = '0; v.pos_x = Depth - 1;
        send_item(1'b0, v);
        v.pos_x = 0;
        send_item(1'b0, v);
        send_item(1'b1, '0);

        // Long receiver hold-off while sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (20) send_lookup();
        join
        wait_drained();   // sender pause until all answers are in

        // Random phases: sender idles 24/recv 69, swapped, then none.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 24 : 0;
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(99) == 0) send_item(1'b1, random_vertex());
                else send_lookup();
                // now and then the sender stops idling for the rest of the phase
                if ($urandom_range(49) == 0) begin
                    send_idle_pct = 0;
                end
            end
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
